/* hw/rtl/minmax_bounding_box_localizer_top_assert.svh */
// Assertion macros for the min-max localizer checker.
// Depends on nothing; included by the checker file.
`ifndef MINMAX_BOUNDING_BOX_LOCALIZER_TOP_ASSERT_SVH
`define MINMAX_BOUNDING_BOX_LOCALIZER_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define MBL_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define MBL_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

/* hw/rtl/mbl_pkg.sv */
// Package for the min-max localizer: payload words, states, constants.
// Depends on nothing.
`default_nettype none
package mbl_pkg;
    localparam int MaxAnchors = 32;
    localparam int IdxW = $clog2(MaxAnchors);
    localparam int CntW = IdxW + 1;
    localparam int CoordW = 24;

    localparam logic [1:0] StOk = 2'd0;
    localparam logic [1:0] StZeroW = 2'd1;
    localparam logic [1:0] StDrop = 2'd2;

    localparam logic [1:0] RegDims = 2'd0;
    localparam logic [1:0] RegUseConf = 2'd1;

    typedef struct packed {
        logic signed [23:0] anchor_x;
        logic signed [23:0] anchor_y;
        logic signed [23:0] anchor_z;
        logic [22:0] meas_range;
        logic [16:0] anchor_conf;
        logic last_anchor;
    } t_in_word;

    typedef struct packed {
        logic signed [23:0] est_x;
        logic signed [23:0] est_y;
        logic signed [23:0] est_z;
        logic [23:0] residual;
        logic [1:0] status;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE, S_EST, S_RD, S_DIFF, S_SQ, S_SQRT, S_ACC, S_DIV, S_OUT
    } t_state;
endpackage
`default_nettype wire

/* hw/rtl/minmax_bounding_box_localizer_top.sv */
// Min-max bounding box localizer top level.
// Depends on mbl_pkg.
`default_nettype none
// Anchors load while idle (busy stays low). On the anchor marked last
// the block goes busy: first the box centre, then per stored anchor
// one store read, a difference and a squaring for each dimension in use
// through one shared multiplier, a 25-step bit-pair square root and one
// accumulate, then a 64-step restoring divider and an output state for
// the weighted mean. The result word shows as busy falls.
// The result shows for one cycle under o_done; the receiver cannot stall
// it, so take it when it appears. Configure only while idle.
module minmax_bounding_box_localizer_top (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             start,
    output logic            busy,
    input  mbl_pkg::t_in_word i_in,
    output logic            o_done,
    output mbl_pkg::t_out_word o_out,
    input  wire             i_cfg_we,
    input  wire [1:0]       i_cfg_idx,
    input  wire [1:0]       i_cfg_data
);
    // anchor store memories (no reset; only read after written in the set)
    logic signed [23:0] r_mem_x [mbl_pkg::MaxAnchors];
    logic signed [23:0] r_mem_y [mbl_pkg::MaxAnchors];
    logic signed [23:0] r_mem_z [mbl_pkg::MaxAnchors];
    logic [22:0] r_mem_r [mbl_pkg::MaxAnchors];
    logic [16:0] r_mem_c [mbl_pkg::MaxAnchors];

    logic [1:0] r_dims;
    logic r_use_conf;
    logic signed [24:0] r_lo [3];
    logic signed [24:0] r_hi [3];
    logic [mbl_pkg::CntW-1:0] r_cnt;
    logic r_ovf;

    mbl_pkg::t_state r_st, n_st;
    logic [mbl_pkg::IdxW-1:0] r_k;
    logic [1:0] r_d;
    logic signed [23:0] r_est [3];
    // read data of the store
    logic signed [23:0] r_px, r_py, r_pz;
    logic [22:0] r_rr;
    logic [16:0] r_rc;
    logic [24:0] r_mag;
    logic [49:0] r_sq;
    logic [49:0] r_rem;
    logic [25:0] r_root;
    logic [4:0] r_it;
    logic [63:0] r_esum;
    logic [40:0] r_wsum_w;
    logic [63:0] r_drem;
    logic [5:0] r_dit;
    logic r_done;
    mbl_pkg::t_out_word r_out;

    logic [1:0] w_nd;
    logic w_acc;
    logic w_room;
    assign w_nd = (r_dims == 2'd0) ? 2'd1 : r_dims;
    assign busy = (r_st != mbl_pkg::S_IDLE);
    assign w_acc = start && !busy;
    assign w_room = (r_cnt < mbl_pkg::CntW'(mbl_pkg::MaxAnchors));
    assign o_done = r_done;
    assign o_out = r_out;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= 2'd2;
            r_use_conf <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mbl_pkg::RegDims: r_dims <= i_cfg_data;
                mbl_pkg::RegUseConf: r_use_conf <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // store write and read
    always_ff @(posedge i_clk) begin
        if (w_acc && w_room) begin
            r_mem_x[r_cnt[mbl_pkg::IdxW-1:0]] <= i_in.anchor_x;
            r_mem_y[r_cnt[mbl_pkg::IdxW-1:0]] <= i_in.anchor_y;
            r_mem_z[r_cnt[mbl_pkg::IdxW-1:0]] <= i_in.anchor_z;
            r_mem_r[r_cnt[mbl_pkg::IdxW-1:0]] <= i_in.meas_range;
            r_mem_c[r_cnt[mbl_pkg::IdxW-1:0]] <= i_in.anchor_conf;
        end
        if (r_st == mbl_pkg::S_RD) begin
            r_px <= r_mem_x[r_k];
            r_py <= r_mem_y[r_k];
            r_pz <= r_mem_z[r_k];
            r_rr <= r_mem_r[r_k];
            r_rc <= r_mem_c[r_k];
        end
    end

    logic signed [24:0] w_pos [3];
    logic signed [24:0] w_rng;
    assign w_pos[0] = 25'(i_in.anchor_x);
    assign w_pos[1] = 25'(i_in.anchor_y);
    assign w_pos[2] = 25'(i_in.anchor_z);
    assign w_rng = $signed({2'b00, i_in.meas_range});

    // shared datapath values
    logic signed [25:0] w_sum;
    logic signed [25:0] w_half;
    logic signed [24:0] w_diff;
    logic signed [23:0] w_pd;
    logic [63:0] w_dsh;
    logic [25:0] w_err;
    logic [25:0] w_dist;
    logic [16:0] w_w;
    assign w_sum = 26'(r_lo[r_d]) + 26'(r_hi[r_d]);
    assign w_half = w_sum >>> 1;
    assign w_pd = (r_d == 2'd0) ? r_px : ((r_d == 2'd1) ? r_py : r_pz);
    assign w_diff = 25'(r_est[r_d]) - 25'(w_pd);
    assign w_dist = r_root;
    assign w_err = (w_dist > 26'(r_rr)) ? (w_dist - 26'(r_rr)) : (26'(r_rr) - w_dist);
    assign w_w = r_use_conf ? r_rc : 17'd1;
    assign w_dsh = {r_drem[62:0], r_esum[63]};

    logic [51:0] w_sqt;
    logic [51:0] w_rem2;
    assign w_rem2 = {r_rem, r_sq[49:48]};
    assign w_sqt = {24'd0, r_root, 2'b01};

    always_comb begin
        n_st = r_st;
        case (r_st)
            mbl_pkg::S_IDLE: if (w_acc && i_in.last_anchor) n_st = mbl_pkg::S_EST;
            mbl_pkg::S_EST: if (r_d == 2'd2)
                n_st = (r_cnt == '0) ? mbl_pkg::S_DIV : mbl_pkg::S_RD;
            mbl_pkg::S_RD: n_st = mbl_pkg::S_DIFF;
            mbl_pkg::S_DIFF: n_st = mbl_pkg::S_SQ;
            mbl_pkg::S_SQ: n_st = (r_d == w_nd - 2'd1) ? mbl_pkg::S_SQRT : mbl_pkg::S_DIFF;
            mbl_pkg::S_SQRT: if (r_it == 5'd24) n_st = mbl_pkg::S_ACC;
            mbl_pkg::S_ACC:
                n_st = (mbl_pkg::CntW'(r_k) + 1'b1 == r_cnt) ? mbl_pkg::S_DIV : mbl_pkg::S_RD;
            mbl_pkg::S_DIV: if (r_dit == 6'd63) n_st = mbl_pkg::S_OUT;
            mbl_pkg::S_OUT: n_st = mbl_pkg::S_IDLE;
            default: n_st = mbl_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= mbl_pkg::S_IDLE;
        else r_st <= n_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
            r_done <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_lo[i] <= '0;
                r_hi[i] <= '0;
            end
        end else begin
            r_done <= 1'b0;
            case (r_st)
                mbl_pkg::S_IDLE: begin
                    r_d <= 2'd0;
                    r_k <= '0;
                    r_esum <= '0;
                    r_wsum_w <= '0;
                    if (w_acc) begin
                        if (w_room) begin
                            for (int i = 0; i < 3; i++) begin
                                if (r_cnt == '0 || w_pos[i] - w_rng > r_lo[i])
                                    r_lo[i] <= w_pos[i] - w_rng;
                                if (r_cnt == '0 || w_pos[i] + w_rng < r_hi[i])
                                    r_hi[i] <= w_pos[i] + w_rng;
                            end
                            r_cnt <= r_cnt + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                end
                mbl_pkg::S_EST: begin
                    // centre, saturated; unused dimensions give zero
                    if (r_d >= w_nd) r_est[r_d] <= '0;
                    else if (w_half > 26'sd8388607) r_est[r_d] <= 24'sh7fffff;
                    else if (w_half < -26'sd8388608) r_est[r_d] <= 24'sh800000;
                    else r_est[r_d] <= w_half[23:0];
                    r_d <= r_d + 2'd1;
                end
                mbl_pkg::S_RD: begin
                    r_d <= 2'd0;
                    r_sq <= '0;
                end
                mbl_pkg::S_DIFF: begin
                    r_mag <= w_diff[24] ? 25'(-w_diff) : w_diff;
                end
                mbl_pkg::S_SQ: begin
                    // shared multiplier
                    r_sq <= r_sq + 50'(r_mag * r_mag);
                    r_d <= r_d + 2'd1;
                    r_rem <= '0;
                    r_root <= '0;
                    r_it <= '0;
                end
                mbl_pkg::S_SQRT: begin
                    // one result bit per step
                    if (r_it != 5'd24 || 1'b1) begin
                        if (w_rem2 >= w_sqt) begin
                            r_rem <= 50'(w_rem2 - w_sqt);
                            r_root <= {r_root[24:0], 1'b1};
                        end else begin
                            r_rem <= w_rem2[49:0];
                            r_root <= {r_root[24:0], 1'b0};
                        end
                        r_sq <= {r_sq[47:0], 2'b00};
                        r_it <= r_it + 5'd1;
                    end
                end
                mbl_pkg::S_ACC: begin
                    r_esum <= r_esum + 64'(w_w * w_err);
                    r_wsum_w <= r_wsum_w + 41'(w_w);
                    r_k <= r_k + 1'b1;
                    r_drem <= '0;
                    r_dit <= '0;
                end
                mbl_pkg::S_DIV: begin
                    // restoring divide, quotient shifted into r_esum
                    if (r_dit == 6'd0 && r_cnt == '0) begin
                        r_drem <= '0;
                    end
                    if (w_dsh >= 64'(r_wsum_w)) begin
                        r_drem <= w_dsh - 64'(r_wsum_w);
                        r_esum <= {r_esum[62:0], 1'b1};
                    end else begin
                        r_drem <= w_dsh;
                        r_esum <= {r_esum[62:0], 1'b0};
                    end
                    r_dit <= r_dit + 6'd1;
                end
                mbl_pkg::S_OUT: begin
                    r_out.est_x <= r_est[0];
                    r_out.est_y <= r_est[1];
                    r_out.est_z <= r_est[2];
                    if (r_wsum_w == '0) begin
                        r_out.residual <= '0;
                        r_out.status <= mbl_pkg::StZeroW;
                    end else begin
                        r_out.residual <= (r_esum[63:24] != '0) ? 24'hffffff : r_esum[23:0];
                        r_out.status <= r_ovf ? mbl_pkg::StDrop : mbl_pkg::StOk;
                    end
                    r_done <= 1'b1;
                    r_cnt <= '0;
                    r_ovf <= 1'b0;
                    for (int i = 0; i < 3; i++) begin
                        r_lo[i] <= '0;
                        r_hi[i] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/mbl_checker.sv */
// Port-level checker for the min-max localizer, bound to the top level.
// Depends on mbl_pkg and the assertion macro header.
`default_nettype none
`include "minmax_bounding_box_localizer_top_assert.svh"
module mbl_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire start,
    input wire busy,
    input wire o_done,
    input mbl_pkg::t_out_word o_out
);
    `MBL_ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done)
    `MBL_ASSERT_IMP(a_done_frees, i_clk, i_rst_n, o_done, !busy)
    `MBL_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_done, o_out.status != 2'd3)
    `MBL_ASSERT_IMP(a_zero_res, i_clk, i_rst_n,
        o_done && o_out.status == mbl_pkg::StZeroW, o_out.residual == 24'd0)
endmodule
bind minmax_bounding_box_localizer_top mbl_checker u_mbl_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_done(o_done), .o_out(o_out)
);
`default_nettype wire
